/* rtl/drop_oldest_frame_queue_assert.svh */
// Assertion macros used by the checker file of the frame queue.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DROP_OLDEST_FRAME_QUEUE_ASSERT_SVH
`define DROP_OLDEST_FRAME_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DOFQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DOFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dofq_pkg.sv */
// Package of the drop-oldest frame queue: sizes, request and event codes,
// and the structs passed between the queue core and the top level.
// No dependencies.
package dofq_pkg;

  localparam int DEPTH         = 16;
  localparam int ENTRY_WIDTH   = 32;
  localparam int STARTUP_LEVEL = 5;

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int FRAME_W = 32;
  localparam int SIZE_W  = 5;
  localparam int OCC_W   = 5;
  localparam int REQ_W   = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH    = 3'd0,
    REQ_POP     = 3'd1,
    REQ_TRY_POP = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_STOP    = 3'd4,
    REQ_RESET   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_HEALTHY = 2'd1,
    EV_CLEARED = 2'd2
  } health_e;

  typedef enum logic {
    CFG_MAX_SIZE  = 1'b0,
    CFG_MIN_MAINT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [SIZE_W-1:0] max_size;
    logic [SIZE_W-1:0] min_maint;
  } cfg_t;

  typedef struct packed {
    logic               accepted;
    logic               frame_valid;
    logic [FRAME_W-1:0] frame_out;
    logic [OCC_W-1:0]   occupancy;
    logic               started;
    health_e            health_event;
    logic               below_maintenance;
    logic               healthy_now;
  } result_t;

endpackage

/* rtl/dofq_core.sv */
// Ring buffer core of the frame queue: entry registers, head pointer, count,
// started and stopped flags, and the result of each transaction.
// Depends on dofq_pkg.
module dofq_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  logic [dofq_pkg::REQ_W-1:0]  req_type_i,
  input  logic [dofq_pkg::FRAME_W-1:0] frame_data_i,
  input  dofq_pkg::cfg_t              cfg_i,
  output dofq_pkg::result_t           res_o
);
  import dofq_pkg::*;

  logic [ENTRY_WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] head_q, head_d, head_inc, wr_idx;
  logic [CNT_W-1:0] count_q, count_d, lim;
  logic [SUM_W-1:0] wr_sum;
  logic             started_q, started_d, stopped_q, stopped_d;
  logic             wr_en, moved;
  req_e             req;

  assign req      = req_e'(req_type_i);
  assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  assign wr_sum   = SUM_W'(head_q) + SUM_W'(count_q);
  assign wr_idx   = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
                                              : PTR_W'(wr_sum);

  always_comb begin
    if (cfg_i.max_size == '0) begin
      lim = CNT_W'(1);
    end else if (int'(cfg_i.max_size) > DEPTH) begin
      lim = CNT_W'(DEPTH);
    end else begin
      lim = CNT_W'(cfg_i.max_size);
    end
  end

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    started_d = started_q;
    stopped_d = stopped_q;
    wr_en     = 1'b0;
    moved     = 1'b0;
    res_o     = '0;
    case (req)
      REQ_PUSH: begin
        if (!stopped_q) begin
          wr_en          = 1'b1;
          moved          = 1'b1;
          res_o.accepted = 1'b1;
          if (count_q >= lim) begin
            head_d = head_inc;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      REQ_POP, REQ_TRY_POP: begin
        if ((req == REQ_TRY_POP || !stopped_q) && count_q != '0) begin
          moved             = 1'b1;
          res_o.frame_valid = 1'b1;
          res_o.frame_out   = FRAME_W'(entry_q[head_q]);
          head_d            = head_inc;
          count_d           = count_q - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        head_d             = '0;
        count_d            = '0;
        started_d          = 1'b0;
        res_o.health_event = EV_CLEARED;
      end
      REQ_STOP: begin
        stopped_d = 1'b1;
      end
      REQ_RESET: begin
        head_d    = '0;
        count_d   = '0;
        started_d = 1'b0;
        stopped_d = 1'b0;
      end
      default: begin
      end
    endcase
    if (moved && !started_q && int'(count_d) >= STARTUP_LEVEL) begin
      started_d          = 1'b1;
      res_o.health_event = EV_HEALTHY;
    end
    res_o.occupancy         = OCC_W'(count_d);
    res_o.started           = started_d;
    res_o.below_maintenance = int'(count_d) < int'(cfg_i.min_maint);
    res_o.healthy_now       = started_d ? (int'(count_d) >= int'(cfg_i.min_maint))
                                        : (int'(count_d) >= int'(cfg_i.max_size));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      started_q <= 1'b0;
      stopped_q <= 1'b0;
    end else if (take_i) begin
      head_q    <= head_d;
      count_q   <= count_d;
      started_q <= started_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && wr_en) begin
      entry_q[wr_idx] <= ENTRY_WIDTH'(frame_data_i);
    end
  end

endmodule

/* rtl/drop_oldest_frame_queue.sv */
// Top level of the drop-oldest frame queue: configuration registers,
// handshake and result register around dofq_core. Depends on dofq_pkg.
//
// Usage: each request transaction (req_type_i, frame_data_i) on the input
// channel is accepted at a rising edge with in_valid_i high and in_stall_o
// low. It produces exactly one result transaction on the output channel,
// taken at an edge with out_valid_o high and out_stall_i low.
// The result is registered at the edge that accepts the request. Throughput
// is one request per cycle while in_stall_o is low; the head pointer, entry
// count and flags of the ring buffer update at the edge that accepts it.
// A new request is accepted while the result register is empty or is being
// taken in the same cycle; while the receiver stalls a waiting result, the
// input is stalled and the result holds.
// The configuration port writes max_size or min_maintenance at any edge
// with cfg_we_i high; write it only while no request is in flight.
// Reset empties the queue, clears the started and stopped flags, drops any
// waiting result and sets max_size to 16 and min_maintenance to 3.
module drop_oldest_frame_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [dofq_pkg::SIZE_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dofq_pkg::REQ_W-1:0]    req_type_i,
  input  logic [dofq_pkg::FRAME_W-1:0]  frame_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic                          frame_valid_o,
  output logic [dofq_pkg::FRAME_W-1:0]  frame_out_o,
  output logic [dofq_pkg::OCC_W-1:0]    occupancy_o,
  output logic                          started_o,
  output logic [1:0]                    health_event_o,
  output logic                          below_maintenance_o,
  output logic                          healthy_now_o
);
  import dofq_pkg::*;

  cfg_t    cfg_q;
  result_t res, res_q;
  logic    out_valid_q, take;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_size  <= SIZE_W'(16);
      cfg_q.min_maint <= SIZE_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_SIZE:  cfg_q.max_size  <= cfg_data_i;
        CFG_MIN_MAINT: cfg_q.min_maint <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dofq_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .req_type_i   (req_type_i),
    .frame_data_i (frame_data_i),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accepted_o          = res_q.accepted;
  assign frame_valid_o       = res_q.frame_valid;
  assign frame_out_o         = res_q.frame_out;
  assign occupancy_o         = res_q.occupancy;
  assign started_o           = res_q.started;
  assign health_event_o      = res_q.health_event;
  assign below_maintenance_o = res_q.below_maintenance;
  assign healthy_now_o       = res_q.healthy_now;

endmodule

/* rtl/dofq_checker.sv */
// Port-level checker of the drop-oldest frame queue and its bind statement.
// Depends on dofq_pkg and drop_oldest_frame_queue_assert.svh.
`include "drop_oldest_frame_queue_assert.svh"

module dofq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          accepted_o,
  input logic                          frame_valid_o,
  input logic [dofq_pkg::FRAME_W-1:0]  frame_out_o,
  input logic [dofq_pkg::OCC_W-1:0]    occupancy_o,
  input logic                          started_o,
  input logic [1:0]                    health_event_o
);
  import dofq_pkg::*;

  `DOFQ_ASSERT_NEXT(a_stalled_result_holds, out_valid_o && out_stall_i,
    out_valid_o && $stable(occupancy_o) && $stable(frame_out_o),
    "stalled result changed")

  `DOFQ_ASSERT_NOW(a_push_pop_exclusive, out_valid_o,
    !(accepted_o && frame_valid_o), "result is both a push and a removal")

  `DOFQ_ASSERT_NOW(a_started_at_level, out_valid_o && int'(occupancy_o) >= STARTUP_LEVEL,
    started_o, "occupancy at startup level without started flag")

  `DOFQ_ASSERT_NOW(a_clear_empties, out_valid_o && health_event_o == EV_CLEARED,
    occupancy_o == '0 && !started_o && !frame_valid_o, "clear left entries behind")

endmodule

bind drop_oldest_frame_queue dofq_checker u_dofq_checker (.*);

/* tb/tb_top.sv */
// Testbench of the drop-oldest frame queue. It sends request transactions, predicts each
// result with its own ring-buffer model of the queue and checks the results in order.
// Depends on dofq_pkg and drop_oldest_frame_queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dofq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic               cfg_idx_i    = 1'b0;
  logic [SIZE_W-1:0]  cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [REQ_W-1:0]   req_type_i   = '0;
  logic [FRAME_W-1:0] frame_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               accepted_o;
  logic               frame_valid_o;
  logic [FRAME_W-1:0] frame_out_o;
  logic [OCC_W-1:0]   occupancy_o;
  logic               started_o;
  logic [1:0]         health_event_o;
  logic               below_maintenance_o;
  logic               healthy_now_o;

  logic [FRAME_W-1:0] ring_store [DEPTH];
  logic [PTR_W-1:0]   ring_head;
  logic [CNT_W-1:0]   ring_count;
  logic               is_started;
  logic               is_stopped;
  logic [SIZE_W-1:0]  lim_max_size;
  logic [SIZE_W-1:0]  lim_min_maint;

  result_t awaited_results [$];
  int      mismatch_count  = 0;
  bit      sender_idles    = 1'b1;
  bit      receiver_stalls = 1'b1;
  bit      hold_request    = 1'b0;

  drop_oldest_frame_queue dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic result_t predict_request(logic [REQ_W-1:0] req,
                                              logic [FRAME_W-1:0] data);
    result_t r;
    int      limit;
    bit      moved;
    r = '0;
    moved = 1'b0;
    limit = (lim_max_size == 0) ? 1 : ((lim_max_size > DEPTH) ? DEPTH : int'(lim_max_size));
    case (req)
      REQ_PUSH: begin
        if (!is_stopped) begin
          if (ring_count >= limit) begin
            ring_head = ring_head + 1'b1;
            ring_count = ring_count - 1'b1;
          end
          if (ring_count < DEPTH) begin
            ring_store[PTR_W'(ring_head + ring_count)] = data;
            ring_count = ring_count + 1'b1;
          end
          r.accepted = 1'b1;
          moved = 1'b1;
        end
      end
      REQ_POP, REQ_TRY_POP: begin
        if ((req == REQ_TRY_POP || !is_stopped) && ring_count != 0) begin
          r.frame_out = ring_store[ring_head];
          r.frame_valid = 1'b1;
          ring_head = ring_head + 1'b1;
          ring_count = ring_count - 1'b1;
          moved = 1'b1;
        end
      end
      REQ_CLEAR: begin
        ring_head = '0;
        ring_count = '0;
        is_started = 1'b0;
        r.health_event = EV_CLEARED;
      end
      REQ_STOP: begin
        is_stopped = 1'b1;
      end
      REQ_RESET: begin
        ring_head = '0;
        ring_count = '0;
        is_started = 1'b0;
        is_stopped = 1'b0;
      end
      default: begin
      end
    endcase
    if (moved && !is_started && ring_count >= STARTUP_LEVEL) begin
      is_started = 1'b1;
      r.health_event = EV_HEALTHY;
    end
    r.occupancy = ring_count;
    r.started = is_started;
    r.below_maintenance = (ring_count < lim_min_maint);
    r.healthy_now = is_started ? (ring_count >= lim_min_maint) : (ring_count >= lim_max_size);
    return r;
  endfunction

  function automatic void check_field(string field, logic [FRAME_W-1:0] want,
                                      logic [FRAME_W-1:0] seen);
    if (want !== seen) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in %s: expected %0h, got %0h", field, want, seen);
      end
    end
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return REQ_PUSH;
    roll = $urandom_range(0, 99);
    if (roll < 70) return REQ_POP;
    if (roll < 82) return REQ_TRY_POP;
    if (roll < 88) return REQ_RESET;
    if (roll < 92) return REQ_CLEAR;
    if (roll < 95) return REQ_STOP;
    return ($urandom_range(0, 1) == 0) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
  endfunction

  task automatic apply_reset();
    ring_head = '0;
    ring_count = '0;
    is_started = 1'b0;
    is_stopped = 1'b0;
    lim_max_size = 5'd16;
    lim_min_maint = 5'd3;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic send_request(logic [REQ_W-1:0] req, logic [FRAME_W-1:0] data);
    int gap;
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    frame_data_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_results.insert(awaited_results.size(), predict_request(req, data));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SIZE_W-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_SIZE) lim_max_size = value;
    else lim_min_maint = value;
  endtask

  task automatic test_directed_basics();
    send_request(REQ_POP, $urandom());
    send_request(REQ_TRY_POP, '0);
    send_request(REQ_PUSH, 32'h0000_0000);
    send_request(REQ_PUSH, 32'hFFFF_FFFF);
    repeat (3) send_request(REQ_PUSH, $urandom());
    send_request(REQ_POP, '0);
    send_request(REQ_TRY_POP, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED_LO, $urandom());
    send_request(REQ_UNUSED_HI, $urandom());
    send_request(REQ_STOP, '0);
    send_request(REQ_PUSH, $urandom());
    send_request(REQ_POP, '0);
    send_request(REQ_TRY_POP, '0);
    send_request(REQ_CLEAR, '0);
    send_request(REQ_CLEAR, '0);
    send_request(REQ_PUSH, $urandom());
    send_request(REQ_RESET, '0);
    send_request(REQ_PUSH, $urandom());
    send_request(REQ_POP, '0);
    send_request(REQ_POP, '0);
  endtask

  task automatic test_register_extremes();
    send_request(REQ_CLEAR, '0);
    write_reg(CFG_MAX_SIZE, 5'd0);
    write_reg(CFG_MIN_MAINT, 5'd0);
    repeat (3) send_request(REQ_PUSH, $urandom());
    repeat (2) send_request(REQ_POP, '0);
    send_request(REQ_CLEAR, '0);
    write_reg(CFG_MAX_SIZE, 5'd31);
    write_reg(CFG_MIN_MAINT, 5'd31);
    repeat (18) send_request(REQ_PUSH, $urandom());
    send_request(REQ_POP, '0);
    send_request(REQ_CLEAR, '0);
    write_reg(CFG_MAX_SIZE, 5'd16);
    write_reg(CFG_MIN_MAINT, 5'd3);
    repeat (10) send_request(REQ_PUSH, $urandom());
    // The limit drops below the current occupancy; nothing is trimmed.
    write_reg(CFG_MAX_SIZE, 5'd4);
    repeat (2) send_request(REQ_PUSH, $urandom());
    send_request(REQ_POP, '0);
    send_request(REQ_CLEAR, '0);
  endtask

  task automatic test_random_phases();
    logic [SIZE_W-1:0] max_list [7];
    logic [SIZE_W-1:0] min_list [7];
    int                push_pct;
    max_list = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd8, 5'd0};
    min_list = '{5'd3, 5'd0, 5'd31, 5'd16, 5'd5, 5'd17, 5'd0};
    max_list[6] = SIZE_W'($urandom_range(0, 31));
    min_list[6] = SIZE_W'($urandom_range(0, 31));
    push_pct = 50;
    for (int p = 0; p < 7; p++) begin
      send_request(REQ_CLEAR, $urandom());
      write_reg(CFG_MAX_SIZE, max_list[p]);
      write_reg(CFG_MIN_MAINT, min_list[p]);
      for (int i = 0; i < 150; i++) begin
        if (i % 40 == 0) push_pct = $urandom_range(25, 80);
        send_request(pick_request(push_pct), $urandom());
      end
    end
  endtask

  task automatic test_backpressure();
    send_request(REQ_RESET, '0);
    hold_request = 1'b1;
    repeat (12) send_request(REQ_PUSH, $urandom());
    repeat (4) send_request(REQ_POP, $urandom());
  endtask

  task automatic test_final_stream();
    int push_pct;
    push_pct = 50;
    send_request(REQ_CLEAR, '0);
    write_reg(CFG_MAX_SIZE, 5'd12);
    write_reg(CFG_MIN_MAINT, 5'd4);
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    for (int i = 0; i < 250; i++) begin
      if (i % 40 == 0) push_pct = $urandom_range(25, 80);
      send_request(pick_request(push_pct), $urandom());
    end
  endtask

  initial begin : receiver_stall
    int span;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (48) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_request = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        span = $urandom_range(1, 9);
        out_stall_i <= 1'b1;
        repeat (span) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result with no request pending: occupancy %0d", occupancy_o);
        end
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        check_field("accepted", FRAME_W'(want.accepted), FRAME_W'(accepted_o));
        check_field("frame_valid", FRAME_W'(want.frame_valid), FRAME_W'(frame_valid_o));
        check_field("frame_out", want.frame_out, frame_out_o);
        check_field("occupancy", FRAME_W'(want.occupancy), FRAME_W'(occupancy_o));
        check_field("started", FRAME_W'(want.started), FRAME_W'(started_o));
        check_field("health_event", FRAME_W'(want.health_event), FRAME_W'(health_event_o));
        check_field("below_maintenance", FRAME_W'(want.below_maintenance),
                    FRAME_W'(below_maintenance_o));
        check_field("healthy_now", FRAME_W'(want.healthy_now), FRAME_W'(healthy_now_o));
      end
    end
  end

  initial begin
    apply_reset();
    test_directed_basics();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    test_final_stream();
    wait_idle();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/dofq_pkg.sv
rtl/dofq_core.sv
rtl/drop_oldest_frame_queue.sv
rtl/dofq_checker.sv
tb/tb_top.sv
